// ===== src/crg_pkg.sv =====
`timescale 1ns / 1ps
package crg_pkg;

  localparam int PIXEL_W       = 12;
  localparam int COORD_MAX     = 16;
  localparam int VEC_W         = 63;
  localparam int COUNT_W       = 8;
  localparam int INDEX_W       = 8;
  localparam int OUT_W         = 32;
  localparam int DEF_COORD     = 12;
  localparam int DEF_COMPONENT = 21;
  localparam int QUEUE_DEPTH   = 4;
  localparam int SAMPLE_IDX_W  = 3;

  localparam logic [INDEX_W-1:0] REG_EYE    = 8'd0;
  localparam logic [INDEX_W-1:0] REG_CORNER = 8'd1;
  localparam logic [INDEX_W-1:0] REG_RIGHT  = 8'd2;
  localparam logic [INDEX_W-1:0] REG_UP     = 8'd3;
  localparam logic [INDEX_W-1:0] REG_COUNT  = 8'd4;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 8'd1;

  typedef enum logic [1:0] {
    MODE_1 = 2'd0,
    MODE_2 = 2'd1,
    MODE_4 = 2'd2,
    MODE_8 = 2'd3
  } crg_mode_t;

  localparam int MODE_W = 2;

  typedef struct packed {
    logic [3:0] right;
    logic [3:0] up;
  } crg_offset_t;

  localparam logic [3:0] PAT8_RIGHT [8] = '{4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11, 4'd13, 4'd15};
  localparam logic [3:0] PAT8_UP    [8] = '{4'd5, 4'd13, 4'd1, 4'd9, 4'd15, 4'd7, 4'd3, 4'd11};
  localparam logic [3:0] PAT4_RIGHT [4] = '{4'd2, 4'd6, 4'd10, 4'd14};
  localparam logic [3:0] PAT4_UP    [4] = '{4'd10, 4'd2, 4'd14, 4'd6};
  localparam logic [3:0] PAT2_BOTH  [2] = '{4'd4, 4'd12};
  localparam logic [3:0] PAT1_BOTH      = 4'd8;

  function automatic crg_mode_t select_mode(input logic [COUNT_W-1:0] cnt);
    crg_mode_t m;
    if (cnt >= 8'd8) begin
      m = MODE_8;
    end else if (cnt >= 8'd4) begin
      m = MODE_4;
    end else if (cnt >= 8'd2) begin
      m = MODE_2;
    end else begin
      m = MODE_1;
    end
    return m;
  endfunction

  function automatic logic [SAMPLE_IDX_W-1:0] last_index(input crg_mode_t m);
    logic [SAMPLE_IDX_W-1:0] r;
    unique case (m)
      MODE_8:  r = 3'd7;
      MODE_4:  r = 3'd3;
      MODE_2:  r = 3'd1;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic crg_offset_t pattern_offset(input crg_mode_t m,
                                                 input logic [SAMPLE_IDX_W-1:0] k);
    crg_offset_t o;
    unique case (m)
      MODE_8: begin
        o.right = PAT8_RIGHT[k];
        o.up    = PAT8_UP[k];
      end
      MODE_4: begin
        o.right = PAT4_RIGHT[k[1:0]];
        o.up    = PAT4_UP[k[1:0]];
      end
      MODE_2: begin
        o.right = PAT2_BOTH[k[0]];
        o.up    = PAT2_BOTH[k[0]];
      end
      default: begin
        o.right = PAT1_BOTH;
        o.up    = PAT1_BOTH;
      end
    endcase
    return o;
  endfunction

endpackage

// ===== src/crg_front.sv =====
`timescale 1ns / 1ps
module crg_front #(
  parameter int COORD_BITS     = 12,
  parameter int COMPONENT_BITS = 21,
  parameter int ACC_W          = 41
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          in_valid,
  output logic                                          in_stall,
  input  logic [crg_pkg::PIXEL_W-1:0]                   pixel_x,
  input  logic [crg_pkg::PIXEL_W-1:0]                   pixel_y,
  input  logic [crg_pkg::VEC_W-1:0]                     screen_corner,
  input  logic [crg_pkg::VEC_W-1:0]                     pixel_right_step,
  input  logic [crg_pkg::VEC_W-1:0]                     pixel_up_step,
  input  logic [crg_pkg::COUNT_W-1:0]                   sample_count,
  input  logic                                          q_full,
  output logic                                          q_push,
  output logic [3*ACC_W+crg_pkg::MODE_W-1:0]            q_data
);
  import crg_pkg::*;

  localparam int PROD_W = COMPONENT_BITS + COORD_BITS + 1;

  logic [COORD_MAX-1:0]        x_ext;
  logic [COORD_MAX-1:0]        y_ext;
  logic signed [COORD_BITS:0]  x_s;
  logic signed [COORD_BITS:0]  y_s;

  logic                               s1_valid;
  logic signed [COMPONENT_BITS-1:0]   s1_corner [3];
  logic signed [PROD_W-1:0]           s1_pr [3];
  logic signed [PROD_W-1:0]           s1_pu [3];
  crg_mode_t                          s1_mode;

  logic                        s2_valid;
  logic signed [ACC_W-1:0]     s2_base [3];
  crg_mode_t                   s2_mode;

  logic s1_ready;
  logic s2_ready;

  assign x_ext = COORD_MAX'(pixel_x);
  assign y_ext = COORD_MAX'(pixel_y);
  assign x_s   = $signed({1'b0, x_ext[COORD_BITS-1:0]});
  assign y_s   = $signed({1'b0, y_ext[COORD_BITS-1:0]});

  assign s2_ready = !s2_valid || !q_full;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_stall = !s1_ready;
  assign q_push   = s2_valid && !q_full;
  assign q_data   = {s2_mode, s2_base[2], s2_base[1], s2_base[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      for (int c = 0; c < 3; c++) begin
        s1_corner[c] <= $signed(screen_corner[c*COMPONENT_BITS +: COMPONENT_BITS]);
        s1_pr[c]     <= $signed(pixel_right_step[c*COMPONENT_BITS +: COMPONENT_BITS]) * x_s;
        s1_pu[c]     <= $signed(pixel_up_step[c*COMPONENT_BITS +: COMPONENT_BITS]) * y_s;
      end
      s1_mode <= select_mode(sample_count);
    end
    if (s2_ready && s1_valid) begin
      for (int c = 0; c < 3; c++) begin
        s2_base[c] <= (ACC_W'(s1_corner[c]) + ACC_W'(s1_pr[c]) + ACC_W'(s1_pu[c])) <<< 4;
      end
      s2_mode <= s1_mode;
    end
  end

endmodule

// ===== src/crg_queue.sv =====
`timescale 1ns / 1ps
module crg_queue #(
  parameter int WIDTH = 125,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output logic [WIDTH-1:0] head
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== src/crg_back.sv =====
`timescale 1ns / 1ps
module crg_back #(
  parameter int COMPONENT_BITS = 21,
  parameter int ACC_W          = 41
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_empty,
  input  logic [3*ACC_W+crg_pkg::MODE_W-1:0]   q_head,
  output logic                                 q_pop,
  input  logic [crg_pkg::VEC_W-1:0]            eye_position,
  input  logic [crg_pkg::VEC_W-1:0]            pixel_right_step,
  input  logic [crg_pkg::VEC_W-1:0]            pixel_up_step,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [crg_pkg::OUT_W-1:0]     start_x,
  output logic signed [crg_pkg::OUT_W-1:0]     start_y,
  output logic signed [crg_pkg::OUT_W-1:0]     start_z,
  output logic signed [crg_pkg::OUT_W-1:0]     heading_x,
  output logic signed [crg_pkg::OUT_W-1:0]     heading_y,
  output logic signed [crg_pkg::OUT_W-1:0]     heading_z,
  output logic                                 last_ray
);
  import crg_pkg::*;

  localparam int OFF_W  = COMPONENT_BITS + 5;
  localparam int ORIG_W = ACC_W - 4;
  localparam int HEAD_W = ORIG_W + 1;
  localparam logic signed [HEAD_W-1:0] SAT_HI = HEAD_W'(32'sh7fffffff);
  localparam logic signed [HEAD_W-1:0] SAT_LO = HEAD_W'(32'sh80000000);

  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [HEAD_W-1:0] v);
    logic signed [HEAD_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end else begin
      r = v;
    end
    return r[OUT_W-1:0];
  endfunction

  crg_mode_t                   mode;
  logic [SAMPLE_IDX_W-1:0]     k;
  logic [SAMPLE_IDX_W-1:0]     k_next;
  crg_offset_t                 off;
  logic                        is_last;
  logic                        issue;
  logic signed [OFF_W-1:0]     off_r [3];
  logic signed [OFF_W-1:0]     off_u [3];
  logic signed [ACC_W-1:0]     sum [3];

  logic                        s1_valid;
  logic                        s1_last;
  logic signed [ACC_W-1:0]     s1_sum [3];
  logic                        s1_ready;
  logic                        out_adv;

  logic signed [ACC_W-1:0]     rounded [3];
  logic signed [HEAD_W-1:0]    orig [3];
  logic signed [HEAD_W-1:0]    head [3];
  logic signed [OUT_W-1:0]     start_sat [3];
  logic signed [OUT_W-1:0]     head_sat [3];

  assign mode    = crg_mode_t'(q_head[3*ACC_W +: MODE_W]);
  assign off     = pattern_offset(mode, k);
  assign is_last = (k == last_index(mode));
  assign out_adv = !out_valid || !out_stall;
  assign s1_ready = !s1_valid || out_adv;
  assign issue   = !q_empty && s1_ready;
  assign q_pop   = issue && is_last;
  assign k_next  = is_last ? '0 : k + 1'b1;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      off_r[c]     = $signed(pixel_right_step[c*COMPONENT_BITS +: COMPONENT_BITS])
                   * $signed({1'b0, off.right});
      off_u[c]     = $signed(pixel_up_step[c*COMPONENT_BITS +: COMPONENT_BITS])
                   * $signed({1'b0, off.up});
      sum[c]       = $signed(q_head[c*ACC_W +: ACC_W])
                   + ACC_W'(off_r[c])
                   + ACC_W'(off_u[c]);
      rounded[c]   = s1_sum[c] + ACC_W'(8);
      orig[c]      = HEAD_W'($signed(rounded[c][ACC_W-1:4]));
      head[c]      = orig[c] - HEAD_W'($signed(eye_position[c*COMPONENT_BITS +: COMPONENT_BITS]));
      start_sat[c] = sat32(orig[c]);
      head_sat[c]  = sat32(head[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        k <= k_next;
      end
      if (s1_ready) begin
        s1_valid <= issue;
      end
      if (out_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      for (int c = 0; c < 3; c++) begin
        s1_sum[c] <= sum[c];
      end
      s1_last <= is_last;
    end
    if (out_adv && s1_valid) begin
      start_x   <= start_sat[0];
      start_y   <= start_sat[1];
      start_z   <= start_sat[2];
      heading_x <= head_sat[0];
      heading_y <= head_sat[1];
      heading_z <= head_sat[2];
      last_ray  <= s1_last;
    end
  end

endmodule

// ===== src/camera_ray_generator.sv =====
`timescale 1ns / 1ps
// Channel  | Handshake            | Beat contents
// ---------+----------------------+------------------------------------------------
// in       | in_valid / in_stall  | pixel_x, pixel_y
// out      | out_valid / out_stall| start_x/y/z, heading_x/y/z, last_ray
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A pixel yields 1, 2, 4 or 8 rays, one ray per cycle while out_stall is low, as set by
// sample_count; the ray sequencer in the back end sets the sustained pixel rate.
// The first ray of a pixel passes the two front-end stages, the queue, the back-end sum stage and the output register.
// Reset clears all handshake state and loads the register reset values.
// The front end keeps taking pixels while the back end stalls, until its two stages
// and the four-entry queue are full.
module camera_ray_generator #(
  parameter int COORD_BITS     = crg_pkg::DEF_COORD,
  parameter int COMPONENT_BITS = crg_pkg::DEF_COMPONENT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [crg_pkg::INDEX_W-1:0]          cfg_index,
  input  logic [crg_pkg::VEC_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [crg_pkg::PIXEL_W-1:0]          pixel_x,
  input  logic [crg_pkg::PIXEL_W-1:0]          pixel_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [crg_pkg::OUT_W-1:0]     start_x,
  output logic signed [crg_pkg::OUT_W-1:0]     start_y,
  output logic signed [crg_pkg::OUT_W-1:0]     start_z,
  output logic signed [crg_pkg::OUT_W-1:0]     heading_x,
  output logic signed [crg_pkg::OUT_W-1:0]     heading_y,
  output logic signed [crg_pkg::OUT_W-1:0]     heading_z,
  output logic                                 last_ray
);
  import crg_pkg::*;

  localparam int ACC_W = (COMPONENT_BITS + COORD_BITS + 8 > 40) ?
                         (COMPONENT_BITS + COORD_BITS + 8) : 40;
  localparam int Q_W   = 3 * ACC_W + MODE_W;

  logic [VEC_W-1:0]   eye_position;
  logic [VEC_W-1:0]   screen_corner;
  logic [VEC_W-1:0]   pixel_right_step;
  logic [VEC_W-1:0]   pixel_up_step;
  logic [COUNT_W-1:0] sample_count;

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  logic [Q_W-1:0] q_in;
  logic [Q_W-1:0] q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eye_position     <= '0;
      screen_corner    <= '0;
      pixel_right_step <= '0;
      pixel_up_step    <= '0;
      sample_count     <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_EYE:    eye_position     <= cfg_data;
        REG_CORNER: screen_corner    <= cfg_data;
        REG_RIGHT:  pixel_right_step <= cfg_data;
        REG_UP:     pixel_up_step    <= cfg_data;
        REG_COUNT:  sample_count     <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  crg_front #(
    .COORD_BITS     (COORD_BITS),
    .COMPONENT_BITS (COMPONENT_BITS),
    .ACC_W          (ACC_W)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .pixel_x          (pixel_x),
    .pixel_y          (pixel_y),
    .screen_corner    (screen_corner),
    .pixel_right_step (pixel_right_step),
    .pixel_up_step    (pixel_up_step),
    .sample_count     (sample_count),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_in)
  );

  crg_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  crg_back #(
    .COMPONENT_BITS (COMPONENT_BITS),
    .ACC_W          (ACC_W)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .eye_position     (eye_position),
    .pixel_right_step (pixel_right_step),
    .pixel_up_step    (pixel_up_step),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .start_x          (start_x),
    .start_y          (start_y),
    .start_z          (start_z),
    .heading_x        (heading_x),
    .heading_y        (heading_y),
    .heading_z        (heading_z),
    .last_ray         (last_ray)
  );

endmodule
